@@ sv/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation codes and status codes shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	typedef enum logic [2:0] {
		KIND_ADD = 3'd0,
		KIND_SUB = 3'd1,
		KIND_MUL = 3'd2,
		KIND_DIV = 3'd3,
		KIND_MOD = 3'd4
	} kind_t;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_SAT  = 2'd1;
	localparam logic [1:0] STATUS_DIVZ = 2'd2;

endpackage

@@ sv/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide and modulus on signed fixed-point complex
// operands, with saturation and a division-by-zero status.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake           Fields
//  input     start, busy         kind, a_re, a_im, b_re, b_im
//  result    done (one cycle)    res_re, res_im, status
//
// Every item runs through a fixed pipeline: input register, multipliers,
// sums, magnitudes, divider setup, then a row of DATA_WIDTH+1 divider cells
// (one per quotient bit, two lanes) beside a row of DATA_WIDTH+1 square root
// cells, then the output register. The done strobe rises together with the
// registered result, which is taken at the edge that ends the strobe; one
// item can enter every cycle, so busy stays low.
// Reset clears the valid bits only. The receiver cannot stall, so done is a
// one-cycle strobe.
//
module complex_arithmetic_unit
	import cau_pkg::*;
#(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [2:0]                   kind,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         busy,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic [1:0]                   status
);
	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * W;          // product width
	localparam int MW = 2 * W + 1;      // signed sum / magnitude width
	localparam int RW = 2 * W + 1;      // divider remainder width
	localparam int NW = MW + F;         // scaled dividend width
	localparam int QW = W + 4;          // root remainder width
	localparam int SQ = 2 * W + 2;      // radicand width
	localparam int NC = W + 1;          // cells per row

	localparam logic [MW-1:0] NMAX = MW'(1) << (W - 1);
	localparam logic [MW-1:0] PMAX = NMAX - MW'(1);

	typedef struct packed {
		logic [2:0]   kind;
		logic [W-1:0] re;
		logic [W-1:0] im;
		logic [1:0]   st;
		logic         neg_re;
		logic         neg_im;
	} side_t;

	// Clamp a sign and magnitude into the result range; top bit flags saturation.
	function automatic logic [W:0] clamp_f(input logic neg, input logic [MW-1:0] m);
		logic [MW-1:0] mc;
		logic [MW-1:0] val;
		logic          sat;
		mc  = m;
		sat = 1'b0;
		if (neg) begin
			if (m > NMAX) begin
				mc  = NMAX;
				sat = 1'b1;
			end
		end else if (m > PMAX) begin
			mc  = PMAX;
			sat = 1'b1;
		end
		val = neg ? (~mc + MW'(1)) : mc;
		return {sat, val[W-1:0]};
	endfunction

	// Stage 1: captured operands.
	logic                v_s1;
	logic [2:0]          kind_s1;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	// Stage 2: products and part-wise sums.
	logic                 v_s2;
	logic [2:0]           kind_s2;
	logic signed [PW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, p_xx_s2, p_yy_s2;
	logic signed [W:0]    as_re_s2, as_im_s2;

	// Stage 3: signed real and imaginary values, squared magnitude.
	logic                 v_s3;
	logic [2:0]           kind_s3;
	logic signed [MW-1:0] val_re_s3, val_im_s3;
	logic [PW-1:0]        den_s3;

	// Stage 4: sign and magnitude.
	logic          v_s4;
	logic [2:0]    kind_s4;
	logic          neg_re_s4, neg_im_s4, dz_s4;
	logic [MW-1:0] mag_re_s4, mag_im_s4;
	logic [PW-1:0] den_s4;

	// Cell rows; index 0 is the setup register, index i+1 the output of cell i.
	logic [RW-1:0] d_rem  [2][NC+1];
	logic [W:0]    d_quo  [2][NC+1];
	logic [W:0]    d_bits [2][NC+1];
	logic [PW-1:0] d_den  [2][NC+1];
	logic          d_ovf  [2][NC+1];
	logic [QW-1:0] r_rem  [NC+1];
	logic [W:0]    r_root [NC+1];
	logic [SQ-1:0] r_bits [NC+1];
	side_t         side_q [NC+1];
	logic [NC:0]   vld_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			vld_q <= '0;
			done  <= 1'b0;
		end else begin
			v_s1  <= start;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			vld_q <= {vld_q[NC-1:0], v_s4};
			done  <= vld_q[NC];
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		ar_s1   <= a_re;
		ai_s1   <= a_im;
		br_s1   <= b_re;
		bi_s1   <= b_im;
	end

	// The two square multipliers serve |b|^2 for divide and |a|^2 for modulus.
	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		p_rr_s2 <= PW'(ar_s1) * PW'(br_s1);
		p_ii_s2 <= PW'(ai_s1) * PW'(bi_s1);
		p_ri_s2 <= PW'(ar_s1) * PW'(bi_s1);
		p_ir_s2 <= PW'(ai_s1) * PW'(br_s1);
		if (kind_s1 == KIND_MOD) begin
			p_xx_s2 <= PW'(ar_s1) * PW'(ar_s1);
			p_yy_s2 <= PW'(ai_s1) * PW'(ai_s1);
		end else begin
			p_xx_s2 <= PW'(br_s1) * PW'(br_s1);
			p_yy_s2 <= PW'(bi_s1) * PW'(bi_s1);
		end
		if (kind_s1 == KIND_SUB) begin
			as_re_s2 <= (W+1)'(ar_s1) - (W+1)'(br_s1);
			as_im_s2 <= (W+1)'(ai_s1) - (W+1)'(bi_s1);
		end else begin
			as_re_s2 <= (W+1)'(ar_s1) + (W+1)'(br_s1);
			as_im_s2 <= (W+1)'(ai_s1) + (W+1)'(bi_s1);
		end
	end

	// Divide forms a times conj(b): (ar*br + ai*bi) + (ai*br - ar*bi)i.
	always_ff @(posedge clk) begin
		kind_s3 <= kind_s2;
		den_s3  <= unsigned'(p_xx_s2) + unsigned'(p_yy_s2);
		unique case (kind_s2)
			KIND_MUL: begin
				val_re_s3 <= MW'(p_rr_s2) - MW'(p_ii_s2);
				val_im_s3 <= MW'(p_ri_s2) + MW'(p_ir_s2);
			end
			KIND_DIV: begin
				val_re_s3 <= MW'(p_rr_s2) + MW'(p_ii_s2);
				val_im_s3 <= MW'(p_ir_s2) - MW'(p_ri_s2);
			end
			default: begin
				val_re_s3 <= MW'(as_re_s2);
				val_im_s3 <= MW'(as_im_s2);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		kind_s4   <= kind_s3;
		neg_re_s4 <= val_re_s3[MW-1];
		neg_im_s4 <= val_im_s3[MW-1];
		mag_re_s4 <= val_re_s3[MW-1] ? unsigned'(-val_re_s3) : unsigned'(val_re_s3);
		mag_im_s4 <= val_im_s3[MW-1] ? unsigned'(-val_im_s3) : unsigned'(val_im_s3);
		den_s4    <= den_s3;
		dz_s4     <= den_s3 == '0;
	end

	// Stage 5: results that need no cell row, plus setup of both rows.
	logic [W:0]    cl_re, cl_im;
	logic [NW-1:0] num_re, num_im;
	logic [NW-1:0] top_re, top_im;
	side_t         side_d;

	always_comb begin
		num_re = NW'(mag_re_s4) << F;
		num_im = NW'(mag_im_s4) << F;
		top_re = num_re >> (W + 1);
		top_im = num_im >> (W + 1);
		if (kind_s4 == KIND_MUL) begin
			cl_re = clamp_f(neg_re_s4, mag_re_s4 >> F);
			cl_im = clamp_f(neg_im_s4, mag_im_s4 >> F);
		end else begin
			cl_re = clamp_f(neg_re_s4, mag_re_s4);
			cl_im = clamp_f(neg_im_s4, mag_im_s4);
		end
		side_d.kind   = kind_s4;
		side_d.neg_re = neg_re_s4;
		side_d.neg_im = neg_im_s4;
		side_d.re     = '0;
		side_d.im     = '0;
		side_d.st     = STATUS_OK;
		unique case (kind_s4)
			KIND_ADD, KIND_SUB, KIND_MUL: begin
				side_d.re = cl_re[W-1:0];
				side_d.im = cl_im[W-1:0];
				side_d.st = (cl_re[W] || cl_im[W]) ? STATUS_SAT : STATUS_OK;
			end
			KIND_DIV: begin
				if (dz_s4) begin
					side_d.st = STATUS_DIVZ;
				end
			end
			default: begin
				side_d.st = STATUS_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		side_q[0]    <= side_d;
		d_rem[0][0]  <= top_re[RW-1:0];
		d_rem[1][0]  <= top_im[RW-1:0];
		d_ovf[0][0]  <= top_re >= NW'(den_s4);
		d_ovf[1][0]  <= top_im >= NW'(den_s4);
		d_bits[0][0] <= num_re[W:0];
		d_bits[1][0] <= num_im[W:0];
		d_quo[0][0]  <= '0;
		d_quo[1][0]  <= '0;
		d_den[0][0]  <= den_s4;
		d_den[1][0]  <= den_s4;
		r_rem[0]     <= '0;
		r_root[0]    <= '0;
		r_bits[0]    <= SQ'(den_s4);
	end

	// The status and sign of each item travel beside the cell rows.
	for (genvar i = 0; i < NC; i++) begin : g_side
		always_ff @(posedge clk) begin
			side_q[i+1] <= side_q[i];
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		for (genvar i = 0; i < NC; i++) begin : g_div
			cau_div_cell #(
				.DATA_WIDTH(DATA_WIDTH)
			) u_cell (
				.clk    (clk),
				.rem_i  (d_rem[l][i]),
				.quo_i  (d_quo[l][i]),
				.bits_i (d_bits[l][i]),
				.den_i  (d_den[l][i]),
				.ovf_i  (d_ovf[l][i]),
				.rem_q  (d_rem[l][i+1]),
				.quo_q  (d_quo[l][i+1]),
				.bits_q (d_bits[l][i+1]),
				.den_q  (d_den[l][i+1]),
				.ovf_q  (d_ovf[l][i+1])
			);
		end
	end

	for (genvar i = 0; i < NC; i++) begin : g_sqrt
		cau_sqrt_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk     (clk),
			.rem_i   (r_rem[i]),
			.root_i  (r_root[i]),
			.sbits_i (r_bits[i]),
			.rem_q   (r_rem[i+1]),
			.root_q  (r_root[i+1]),
			.sbits_q (r_bits[i+1])
		);
	end

	// Output stage: pick the row result for divide and modulus and clamp it.
	side_t         fin;
	logic [MW-1:0] qm_re, qm_im;
	logic [W:0]    q_re, q_im, q_rt;

	always_comb begin
		fin   = side_q[NC];
		// A quotient at or above 2^(W+1) saturates whatever its low bits are.
		qm_re = d_ovf[0][NC] ? '1 : MW'(d_quo[0][NC]);
		qm_im = d_ovf[1][NC] ? '1 : MW'(d_quo[1][NC]);
		q_re  = clamp_f(fin.neg_re, qm_re);
		q_im  = clamp_f(fin.neg_im, qm_im);
		q_rt  = clamp_f(1'b0, MW'(r_root[NC]));
	end

	always_ff @(posedge clk) begin
		res_re <= fin.re;
		res_im <= fin.im;
		status <= fin.st;
		if (fin.kind == KIND_DIV && fin.st != STATUS_DIVZ) begin
			res_re <= q_re[W-1:0];
			res_im <= q_im[W-1:0];
			status <= (q_re[W] || q_im[W]) ? STATUS_SAT : STATUS_OK;
		end else if (fin.kind == KIND_MOD) begin
			res_re <= q_rt[W-1:0];
			res_im <= '0;
			status <= q_rt[W] ? STATUS_SAT : STATUS_OK;
		end
	end

endmodule

@@ sv/cau_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: brings in one dividend bit, produces one
// quotient bit and hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module cau_div_cell #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                      clk,
	input  logic [2*DATA_WIDTH:0]     rem_i,
	input  logic [DATA_WIDTH:0]       quo_i,
	input  logic [DATA_WIDTH:0]       bits_i,
	input  logic [2*DATA_WIDTH-1:0]   den_i,
	input  logic                      ovf_i,
	output logic [2*DATA_WIDTH:0]     rem_q,
	output logic [DATA_WIDTH:0]       quo_q,
	output logic [DATA_WIDTH:0]       bits_q,
	output logic [2*DATA_WIDTH-1:0]   den_q,
	output logic                      ovf_q
);
	localparam int W  = DATA_WIDTH;
	localparam int RW = 2 * W + 1;

	logic [RW-1:0] trial;
	logic [RW-1:0] diff;
	logic          fits;

	// The incoming remainder is below the divisor, so its top bit is free.
	assign trial = {rem_i[RW-2:0], bits_i[W]};
	assign fits  = trial >= RW'(den_i);
	assign diff  = trial - RW'(den_i);

	always_ff @(posedge clk) begin
		rem_q  <= fits ? diff : trial;
		quo_q  <= {quo_i[W-1:0], fits};
		bits_q <= {bits_i[W-1:0], 1'b0};
		den_q  <= den_i;
		ovf_q  <= ovf_i;
	end

endmodule

@@ sv/cau_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Square root cell
// One digit-by-digit square root step: brings in two radicand bits and
// produces one root bit.
// ----------------------------------------------------------------------------
module cau_sqrt_cell #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                      clk,
	input  logic [DATA_WIDTH+3:0]     rem_i,
	input  logic [DATA_WIDTH:0]       root_i,
	input  logic [2*DATA_WIDTH+1:0]   sbits_i,
	output logic [DATA_WIDTH+3:0]     rem_q,
	output logic [DATA_WIDTH:0]       root_q,
	output logic [2*DATA_WIDTH+1:0]   sbits_q
);
	localparam int W  = DATA_WIDTH;
	localparam int QW = W + 4;
	localparam int SW = 2 * W + 2;

	logic [QW-1:0] rs;
	logic [QW-1:0] trial;
	logic          fits;

	assign rs    = {rem_i[QW-3:0], sbits_i[SW-1:SW-2]};
	assign trial = QW'({root_i, 2'b01});
	assign fits  = rs >= trial;

	always_ff @(posedge clk) begin
		rem_q   <= fits ? (rs - trial) : rs;
		root_q  <= {root_i[W-1:0], fits};
		sbits_q <= {sbits_i[SW-3:0], 2'b00};
	end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives add, subtract, multiply, divide and modulus items with directed
// corners and random operands, predicts each result in fixed point and
// checks every done strobe against the oldest prediction in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cau_pkg::*;

	localparam int DW = 16;
	localparam int FB = 8;
	localparam int LATENCY = DW + 7;

	// One predicted result of the unit.
	typedef struct {
		logic [DW-1:0] re;
		logic [DW-1:0] im;
		logic [1:0]    st;
	} cplx_res_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic [2:0]    kind;
	logic [DW-1:0] a_re, a_im, b_re, b_im;
	logic          busy;
	logic          done;
	logic [DW-1:0] res_re, res_im;
	logic [1:0]    status;

	cplx_res_t pending_results[$];
	int        mismatch_count;
	int        result_count;
	int        sent_count;
	int        kind_counts[8];
	bit        idle_enabled;

	complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(kind),
		.a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.busy(busy), .done(done), .res_re(res_re), .res_im(res_im),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Clamp a signed value given as sign and magnitude to the result range.
	function automatic logic [DW-1:0] clamp_mag(bit neg, logic [63:0] m, ref bit sat);
		logic [63:0] pmax;
		logic [63:0] nmax;
		pmax = (64'd1 << (DW - 1)) - 1;
		nmax = 64'd1 << (DW - 1);
		if (neg) begin
			if (m > nmax) begin
				sat = 1'b1;
				m = nmax;
			end
			return DW'(-m);
		end
		if (m > pmax) begin
			sat = 1'b1;
			m = pmax;
		end
		return DW'(m);
	endfunction

	function automatic logic [63:0] abs64(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	// Bit-serial quotient floor(n * 2^FB / d), capped at 2^40.
	function automatic logic [63:0] scaled_quotient(logic [63:0] n, logic [63:0] d);
		logic [63:0] r;
		logic [63:0] q;
		logic        nb;
		r = 0;
		q = 0;
		for (int i = 0; i < 64 + FB; i++) begin
			nb = (i < 64) ? n[63-i] : 1'b0;
			r = {r[62:0], nb};
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
			if (q > (64'd1 << 40)) q = 64'd1 << 40;
		end
		return q;
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] x);
		logic [63:0] root;
		logic [63:0] b;
		root = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= root + b) begin
				x = x - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	// Predict the unit's result for one item.
	function automatic cplx_res_t predict_complex(logic [2:0] k, logic [DW-1:0] ar_v,
			logic [DW-1:0] ai_v, logic [DW-1:0] br_v, logic [DW-1:0] bi_v);
		cplx_res_t   r;
		longint      ar, ai, br, bi, pr, pi;
		logic [63:0] den;
		bit          sat;
		ar = longint'($signed(ar_v));
		ai = longint'($signed(ai_v));
		br = longint'($signed(br_v));
		bi = longint'($signed(bi_v));
		sat = 1'b0;
		r.re = '0;
		r.im = '0;
		r.st = STATUS_OK;
		case (k)
			KIND_ADD: begin
				r.re = clamp_mag(ar + br < 0, abs64(ar + br), sat);
				r.im = clamp_mag(ai + bi < 0, abs64(ai + bi), sat);
			end
			KIND_SUB: begin
				r.re = clamp_mag(ar - br < 0, abs64(ar - br), sat);
				r.im = clamp_mag(ai - bi < 0, abs64(ai - bi), sat);
			end
			KIND_MUL: begin
				pr = ar * br - ai * bi;
				pi = ar * bi + ai * br;
				r.re = clamp_mag(pr < 0, abs64(pr) >> FB, sat);
				r.im = clamp_mag(pi < 0, abs64(pi) >> FB, sat);
			end
			KIND_DIV: begin
				den = 64'(br * br) + 64'(bi * bi);
				if (den == 0) begin
					r.st = STATUS_DIVZ;
				end else begin
					// Numerator is a times the conjugate of b.
					pr = ar * br + ai * bi;
					pi = ai * br - ar * bi;
					r.re = clamp_mag(pr < 0, scaled_quotient(abs64(pr), den), sat);
					r.im = clamp_mag(pi < 0, scaled_quotient(abs64(pi), den), sat);
				end
			end
			KIND_MOD: begin
				r.re = clamp_mag(1'b0, floor_sqrt(64'(ar * ar) + 64'(ai * ai)), sat);
			end
			default: ;
		endcase
		if (r.st == STATUS_OK && sat) r.st = STATUS_SAT;
		return r;
	endfunction

	// Send one item: optional random idle burst, then hold start until the
	// unit accepts it. Start stays high across back-to-back items.
	task automatic send_item(logic [2:0] k, logic [DW-1:0] ar, logic [DW-1:0] ai,
			logic [DW-1:0] br, logic [DW-1:0] bi);
		if (idle_enabled && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		a_re <= ar;
		a_im <= ai;
		b_re <= br;
		b_im <= bi;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_complex(k, ar, ai, br, bi));
		sent_count++;
		kind_counts[k]++;
	endtask

	// Results are sampled at the edge that ends the strobe cycle.
	always @(posedge clk) begin
		cplx_res_t exp_r;
		if (arst_n && done) begin
			result_count++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("error: unexpected result re=%h im=%h st=%0d",
						res_re, res_im, status);
			end else begin
				exp_r = pending_results.pop_front();
				if (res_re !== exp_r.re || res_im !== exp_r.im || status !== exp_r.st) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("error: result %0d expected re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
							result_count, exp_r.re, exp_r.im, exp_r.st,
							res_re, res_im, status);
				end
			end
		end
	end

	function automatic logic [DW-1:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return '0;
			3: return DW'($signed($urandom_range(0, 1023)) - 512);
			default: return DW'($urandom);
		endcase
	endfunction

	// Extremes of every field for each operation, including two unused kinds.
	task automatic test_corners();
		logic [DW-1:0] v[4];
		v = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
		for (int k = 0; k < 5; k++) begin
			send_item(3'(k), v[0], v[0], v[0], v[0]);
			send_item(3'(k), v[1], v[1], v[1], v[1]);
			send_item(3'(k), v[1], v[0], v[3], v[1]);
		end
		send_item(3'd5, 16'h7fff, 16'h8000, 16'h1234, 16'h8001);
		send_item(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
	endtask

	// Division by zero, tiny divisors that saturate the quotient, an ordinary divide and a modulus.
	task automatic test_divide_special();
		send_item(KIND_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
		send_item(KIND_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_item(KIND_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
		send_item(KIND_DIV, 16'h0100, 16'h0000, 16'h0000, 16'h0001);
		send_item(KIND_DIV, 16'h0300, 16'h0400, 16'h0100, 16'h0000);
		send_item(KIND_MOD, 16'h0300, 16'h0400, 16'h0000, 16'h0000);
	endtask

	task automatic test_random(int n);
		logic [2:0] k;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			if (k == KIND_DIV && $urandom_range(0, 15) == 0)
				send_item(k, rand_operand(), rand_operand(), '0, '0);
			else
				send_item(k, rand_operand(), rand_operand(), rand_operand(),
					rand_operand());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = '0;
		a_re = '0;
		a_im = '0;
		b_re = '0;
		b_im = '0;
		mismatch_count = 0;
		result_count = 0;
		sent_count = 0;
		idle_enabled = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		test_divide_special();
		test_random(750);
		// Closing stretch runs back to back.
		idle_enabled = 1'b0;
		test_random(150);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		$display("covered %0d items: add %0d, sub %0d, mul %0d, div %0d, mod %0d, unused %0d",
			sent_count, kind_counts[0], kind_counts[1], kind_counts[2], kind_counts[3],
			kind_counts[4], kind_counts[5] + kind_counts[6] + kind_counts[7]);
		$display("%0d results checked, %0d mismatches", result_count, mismatch_count);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog: fails the run if it has not finished on its own.
	initial begin
		#1ms;
		$display("status: fail");
		$finish;
	end

endmodule
